[hw/rtl/base32_stream_codec_assert.svh]
// assertion macros shared by the base32 codec checker
// no dependencies; include with the bare file name
`ifndef BASE32_STREAM_CODEC_ASSERT_SVH
`define BASE32_STREAM_CODEC_ASSERT_SVH

// implication checked on the same edge, masked while reset is asserted
`define B32C_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("b32c: assertion failed");

// implication checked on the following edge, masked while reset is asserted
`define B32C_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("b32c: assertion failed");

// implication on the following edge, also active during reset
`define B32C_ASSERT_NEXT_ALWAYS(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("b32c: assertion failed");

`endif

[hw/rtl/b32c_pkg.sv]
// shared types, codes and alphabet functions of the base32 codec
// no dependencies
package b32c_pkg;

  localparam int unsigned BITS_W = 40;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_LOWER = 1'b1;

  localparam logic [7:0] CHAR_PAD = 8'h3d;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_Z   = 8'h5a;
  localparam logic [7:0] CHAR_LA  = 8'h61;
  localparam logic [7:0] CHAR_LZ  = 8'h7a;
  localparam logic [7:0] CHAR_2   = 8'h32;
  localparam logic [7:0] CHAR_7   = 8'h37;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [1:0] {
    JOB_ENC,
    JOB_DEC,
    JOB_ERR
  } job_kind_t;

  // one converted group waiting for the output side
  typedef struct packed {
    job_kind_t         kind;
    logic [BITS_W-1:0] bits;    // left-aligned group bits
    logic [3:0]        nres;    // results to emit, 1..8
    logic [3:0]        nch;     // encoder: data characters before padding
    logic              last;
    logic [1:0]        status;
  } job_t;

  typedef struct packed {
    logic direction;
    logic accept_lower;
  } cfg_t;

  function automatic logic [7:0] symbol(input logic [4:0] v);
    logic [7:0] w;
    w = {3'b000, v};
    if (v < 5'd26) begin
      return CHAR_A + w;
    end
    return CHAR_2 + (w - 8'd26);
  endfunction

  // bit 5 set means the character is outside the alphabet
  function automatic logic [5:0] char_value(input logic [7:0] c, input logic lower);
    logic [7:0] u;
    logic [7:0] d;
    u = (lower && c >= CHAR_LA && c <= CHAR_LZ) ? c - CASE_GAP : c;
    d = 8'h00;
    if (u >= CHAR_A && u <= CHAR_Z) begin
      d = u - CHAR_A;
      return {1'b0, d[4:0]};
    end
    if (u >= CHAR_2 && u <= CHAR_7) begin
      d = u - CHAR_2 + 8'd26;
      return {1'b0, d[4:0]};
    end
    return 6'b100000;
  endfunction

  function automatic logic [3:0] enc_chars(input logic [2:0] n);
    case (n)
      3'd1:    return 4'd2;
      3'd2:    return 4'd4;
      3'd3:    return 4'd5;
      3'd4:    return 4'd7;
      3'd5:    return 4'd8;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [3:0] dec_bytes(input logic [3:0] d);
    case (d)
      4'd2:    return 4'd1;
      4'd4:    return 4'd2;
      4'd5:    return 4'd3;
      4'd7:    return 4'd4;
      4'd8:    return 4'd5;
      default: return 4'd0;
    endcase
  endfunction

endpackage

[hw/rtl/base32_stream_codec.sv]
// base32 encoder/decoder: an accepted item that closes a group or raises an error
// pushes a job; the back end unrolls the queue head into registered output results.
// output side gives one result per cycle unless out_stall holds it; encoding gives
// 8 results per 5 bytes; decoding takes one character per cycle unless in_stall is set.
// synchronous active-low reset clears stream control state, the queue and out_valid, and
// sets direction to encode with lowercase rejected; a direction write restarts the stream.
module base32_stream_codec #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [b32c_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [b32c_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_byte,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_byte,
  output logic                                out_last,
  output logic [1:0]                          out_status
);

  b32c_pkg::cfg_t cfg_r, cfg_nxt;
  logic           stream_clr;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  b32c_pkg::job_t push_job;
  b32c_pkg::job_t head_job;

  always_comb begin
    cfg_nxt    = cfg_r;
    stream_clr = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        b32c_pkg::REG_DIRECTION: begin
          cfg_nxt.direction = cfg_data[0];
          stream_clr        = 1'b1;
        end
        b32c_pkg::REG_ACCEPT_LOWER: cfg_nxt.accept_lower = cfg_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  b32c_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .stream_clr (stream_clr),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  b32c_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_push),
    .wr_data   (push_job),
    .rd_en     (q_pop),
    .rd_data   (head_job),
    .full      (q_full),
    .not_empty (q_valid)
  );

  b32c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule

[hw/rtl/b32c_front.sv]
// input side of the base32 codec: gathers groups and queues conversion jobs
// depends on b32c_pkg
module b32c_front (
  input  logic                clk,
  input  logic                rst_n,
  input  b32c_pkg::cfg_t      cfg,
  input  logic                stream_clr,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                q_full,
  output logic                q_push,
  output b32c_pkg::job_t      q_job
);

  logic [b32c_pkg::BITS_W-1:0] gbits_r, gbits_nxt;
  logic [3:0]                  gcnt_r, gcnt_nxt;
  logic [3:0]                  dchars_r, dchars_nxt;
  logic                        pad_r, pad_nxt;
  logic                        disc_r, disc_nxt;

  logic                        acc;
  logic [3:0]                  gcnt_inc;
  logic [3:0]                  dchars_inc;
  logic [2:0]                  enc_n;
  logic [5:0]                  enc_sh;
  logic [b32c_pkg::BITS_W-1:0] gb_enc;
  logic [b32c_pkg::BITS_W-1:0] gb_dec;
  logic [5:0]                  cv;
  logic                        is_pad;
  logic [3:0]                  dsel;
  logic [b32c_pkg::BITS_W-1:0] gsel;
  logic [5:0]                  dgap;
  logic [5:0]                  dec_sh;
  logic [3:0]                  nb;
  logic                        pad_upd;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  assign gcnt_inc   = gcnt_r + 4'd1;
  assign dchars_inc = dchars_r + 4'd1;
  assign enc_n      = (gcnt_inc > 4'd5) ? 3'd5 : gcnt_inc[2:0];
  assign enc_sh     = {3'd5 - enc_n, 3'b000};
  assign gb_enc     = {gbits_r[b32c_pkg::BITS_W-9:0], in_byte};

  assign cv      = b32c_pkg::char_value(in_byte, cfg.accept_lower);
  assign is_pad  = (in_byte == b32c_pkg::CHAR_PAD);
  assign gb_dec  = {gbits_r[b32c_pkg::BITS_W-6:0], cv[4:0]};
  assign dsel    = is_pad ? dchars_r : dchars_inc;
  assign gsel    = is_pad ? gbits_r : gb_dec;
  assign dgap    = {2'b00, 4'd8 - dsel};
  assign dec_sh  = (dgap << 2) + dgap;
  assign nb      = b32c_pkg::dec_bytes(dsel);
  assign pad_upd = pad_r || is_pad;

  always_comb begin
    gbits_nxt  = gbits_r;
    gcnt_nxt   = gcnt_r;
    dchars_nxt = dchars_r;
    pad_nxt    = pad_r;
    disc_nxt   = disc_r;
    q_push     = 1'b0;
    q_job      = '0;
    q_job.last = in_last;

    if (acc) begin
      if (!cfg.direction) begin
        if (gcnt_inc >= 4'd5 || in_last) begin
          q_push      = 1'b1;
          q_job.kind  = b32c_pkg::JOB_ENC;
          q_job.bits  = gb_enc << enc_sh;
          q_job.nres  = 4'd8;
          q_job.nch   = b32c_pkg::enc_chars(enc_n);
          q_job.status = b32c_pkg::STATUS_OK;
          gbits_nxt   = '0;
          gcnt_nxt    = 4'd0;
          dchars_nxt  = 4'd0;
        end else begin
          gbits_nxt = gb_enc;
          gcnt_nxt  = gcnt_inc;
        end
      end else if (disc_r) begin
        if (in_last) begin
          disc_nxt = 1'b0;
        end
      end else if (!is_pad && (cv[5] || pad_r)) begin
        q_push       = 1'b1;
        q_job.kind   = b32c_pkg::JOB_ERR;
        q_job.nres   = 4'd1;
        q_job.last   = 1'b1;
        q_job.status = b32c_pkg::STATUS_BAD_CHAR;
        gbits_nxt    = '0;
        gcnt_nxt     = 4'd0;
        dchars_nxt   = 4'd0;
        pad_nxt      = 1'b0;
        disc_nxt     = !in_last;
      end else if (gcnt_inc >= 4'd8 || in_last) begin
        q_push     = 1'b1;
        gbits_nxt  = '0;
        gcnt_nxt   = 4'd0;
        dchars_nxt = 4'd0;
        if (nb == 4'd0) begin
          q_job.kind   = b32c_pkg::JOB_ERR;
          q_job.nres   = 4'd1;
          q_job.last   = 1'b1;
          q_job.status = b32c_pkg::STATUS_BAD_LEN;
          pad_nxt      = 1'b0;
          disc_nxt     = !in_last;
        end else begin
          q_job.kind   = b32c_pkg::JOB_DEC;
          q_job.bits   = gsel << dec_sh;
          q_job.nres   = nb;
          q_job.status = b32c_pkg::STATUS_OK;
          pad_nxt      = in_last ? 1'b0 : pad_upd;
        end
      end else begin
        gbits_nxt  = gsel;
        gcnt_nxt   = gcnt_inc;
        dchars_nxt = dsel;
        pad_nxt    = pad_upd;
      end
    end

    // a direction write restarts the stream
    if (stream_clr) begin
      gbits_nxt  = '0;
      gcnt_nxt   = 4'd0;
      dchars_nxt = 4'd0;
      pad_nxt    = 1'b0;
      disc_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    gbits_r <= gbits_nxt;
    if (!rst_n) begin
      gcnt_r   <= 4'd0;
      dchars_r <= 4'd0;
      pad_r    <= 1'b0;
      disc_r   <= 1'b0;
    end else begin
      gcnt_r   <= gcnt_nxt;
      dchars_r <= dchars_nxt;
      pad_r    <= pad_nxt;
      disc_r   <= disc_nxt;
    end
  end

endmodule

[hw/rtl/b32c_fifo.sv]
// short job queue between the front and back of the base32 codec
// depends on b32c_pkg
module b32c_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  b32c_pkg::job_t wr_data,
  input  logic           rd_en,
  output b32c_pkg::job_t rd_data,
  output logic           full,
  output logic           not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  b32c_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/b32c_back.sv]
// output side of the base32 codec: unrolls queued jobs into results
// depends on b32c_pkg
module b32c_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  b32c_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic [1:0]     out_status
);

  logic [2:0]                  idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r, out_byte_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [1:0]                  out_status_r, out_status_nxt;

  logic                        load;
  logic                        final_res;
  logic [5:0]                  sh5;
  logic [5:0]                  sh8;
  logic [b32c_pkg::BITS_W-1:0] bits5;
  logic [b32c_pkg::BITS_W-1:0] bits8;
  logic [7:0]                  res_byte;

  assign load      = q_valid && (!out_valid_r || !out_stall);
  assign final_res = ({1'b0, idx_r} == (q_job.nres - 4'd1));
  assign sh5       = ({3'b000, idx_r} << 2) + {3'b000, idx_r};
  assign sh8       = {idx_r, 3'b000};
  assign bits5     = q_job.bits << sh5;
  assign bits8     = q_job.bits << sh8;
  assign q_pop     = load && final_res;

  always_comb begin
    unique case (q_job.kind)
      b32c_pkg::JOB_ENC: begin
        res_byte = ({1'b0, idx_r} < q_job.nch) ?
                   b32c_pkg::symbol(bits5[b32c_pkg::BITS_W-1 -: 5]) : b32c_pkg::CHAR_PAD;
      end
      b32c_pkg::JOB_DEC: res_byte = bits8[b32c_pkg::BITS_W-1 -: 8];
      default:           res_byte = 8'h00;
    endcase
  end

  always_comb begin
    idx_nxt        = idx_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = res_byte;
      out_last_nxt   = final_res && q_job.last;
      out_status_nxt = q_job.status;
      idx_nxt        = final_res ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

[hw/rtl/b32c_checker.sv]
// port-level checks of the base32 codec, bound to the top level
// depends on b32c_pkg and base32_stream_codec_assert.svh
`include "base32_stream_codec_assert.svh"

module b32c_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [7:0]                      out_byte,
  input logic                            out_last,
  input logic [1:0]                      out_status
);

  logic        err_res;
  logic        status_known;
  logic [10:0] out_payload;

  assign err_res      = out_valid && (out_status != b32c_pkg::STATUS_OK);
  assign status_known = (out_status == b32c_pkg::STATUS_OK) ||
                        (out_status == b32c_pkg::STATUS_BAD_CHAR) ||
                        (out_status == b32c_pkg::STATUS_BAD_LEN);
  assign out_payload  = {out_byte, out_last, out_status};

  // an error transaction always closes the message
  `B32C_ASSERT_SAME(a_err_is_last, clk, rst_n, err_res, out_last)

  `B32C_ASSERT_SAME(a_status_code, clk, rst_n, out_valid, status_known)

  `B32C_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))

  `B32C_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid)

endmodule

bind base32_stream_codec b32c_checker u_b32c_checker (.*);

[test/tb_base32_stream_codec.sv]
// self-checking testbench for base32_stream_codec: encode and decode streams
// checked against a cycle-free predictor; depends on b32c_pkg and the codec rtl
module tb_base32_stream_codec;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int SEG_ITEMS     = 45;
  localparam logic DIR_ENCODE  = 1'b0;
  localparam logic DIR_DECODE  = 1'b1;
  localparam logic [8*32-1:0] ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } b32_res_t;

  typedef struct packed {
    logic       dir;
    logic       lower;
    logic [7:0] data;
    logic       last;
    logic       typed;
    b32_res_t   exp;
  } stim_row_t;

  localparam b32_res_t NO_EXP  = '{8'h00, 1'b0, b32c_pkg::STATUS_OK};
  localparam b32_res_t BAD_CH  = '{8'h00, 1'b1, b32c_pkg::STATUS_BAD_CHAR};
  localparam b32_res_t BAD_LN  = '{8'h00, 1'b1, b32c_pkg::STATUS_BAD_LEN};
  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{DIR_ENCODE, 1'b0, 8'h00, 1'b1, 1'b0, NO_EXP},
    '{DIR_ENCODE, 1'b0, 8'hff, 1'b0, 1'b0, NO_EXP},
    '{DIR_ENCODE, 1'b0, 8'hff, 1'b0, 1'b0, NO_EXP},
    '{DIR_ENCODE, 1'b0, 8'hff, 1'b0, 1'b0, NO_EXP},
    '{DIR_ENCODE, 1'b0, 8'hff, 1'b0, 1'b0, NO_EXP},
    '{DIR_ENCODE, 1'b0, 8'hff, 1'b1, 1'b0, NO_EXP},
    '{DIR_ENCODE, 1'b0, 8'ha5, 1'b0, 1'b0, NO_EXP},
    '{DIR_ENCODE, 1'b0, 8'h5a, 1'b1, 1'b0, NO_EXP},
    // short group ended by padding and last
    '{DIR_DECODE, 1'b0, b32c_pkg::CHAR_7, 1'b0, 1'b0, NO_EXP},
    '{DIR_DECODE, 1'b0, b32c_pkg::CHAR_7, 1'b0, 1'b0, NO_EXP},
    '{DIR_DECODE, 1'b0, b32c_pkg::CHAR_PAD, 1'b1, 1'b1, '{8'hff, 1'b1, b32c_pkg::STATUS_OK}},
    '{DIR_DECODE, 1'b0, "!", 1'b1, 1'b1, BAD_CH},
    '{DIR_DECODE, 1'b0, b32c_pkg::CHAR_A, 1'b1, 1'b1, BAD_LN},
    // group of padding only
    '{DIR_DECODE, 1'b0, b32c_pkg::CHAR_PAD, 1'b1, 1'b1, BAD_LN},
    '{DIR_DECODE, 1'b0, b32c_pkg::CHAR_LA, 1'b1, 1'b1, BAD_CH},
    // data character after padding
    '{DIR_DECODE, 1'b0, b32c_pkg::CHAR_A, 1'b0, 1'b0, NO_EXP},
    '{DIR_DECODE, 1'b0, b32c_pkg::CHAR_A, 1'b0, 1'b0, NO_EXP},
    '{DIR_DECODE, 1'b0, b32c_pkg::CHAR_PAD, 1'b0, 1'b0, NO_EXP},
    '{DIR_DECODE, 1'b0, "B", 1'b1, 1'b1, BAD_CH},
    // error mid-message, rest of it dropped
    '{DIR_DECODE, 1'b0, 8'h00, 1'b0, 1'b1, BAD_CH},
    '{DIR_DECODE, 1'b0, "B", 1'b0, 1'b0, NO_EXP},
    '{DIR_DECODE, 1'b0, "C", 1'b1, 1'b0, NO_EXP},
    '{DIR_DECODE, 1'b1, b32c_pkg::CHAR_LZ, 1'b0, 1'b0, NO_EXP},
    '{DIR_DECODE, 1'b1, b32c_pkg::CHAR_LZ, 1'b1, 1'b0, NO_EXP},
    '{DIR_DECODE, 1'b1, 8'hff, 1'b1, 1'b1, BAD_CH}
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [b32c_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [b32c_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [7:0]                      in_byte = 8'h00;
  logic                            in_last = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [7:0]                      out_byte;
  logic                            out_last;
  logic [1:0]                      out_status;

  // travels with each input transaction; a typed row overrides the predictor
  logic     item_typed = 1'b0;
  b32_res_t item_exp = '0;

  base32_stream_codec dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_status(out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic        codec_dir = DIR_ENCODE;
  logic        codec_lower = 1'b0;
  logic [39:0] grp_bits = '0;
  logic [3:0]  grp_cnt = '0;
  logic [3:0]  data_cnt = '0;
  logic        pad_seen = 1'b0;
  logic        discarding = 1'b0;

  b32_res_t pending_results[$];
  logic [7:0] msg_q[$];

  int fail_cnt = 0;
  int n_in = 0;
  int n_out = 0;
  int n_err = 0;
  int cycle_cnt = 0;
  int stall_pct = 0;
  int idle_pct = 0;
  int lower_pct = 0;

  function automatic void add_result(input b32_res_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_char(input logic [7:0] c);
    msg_q.insert(msg_q.size(), c);
  endfunction

  function automatic logic [7:0] sym_to_char(input logic [4:0] v);
    return ALPHABET[8*(31 - v) +: 8];
  endfunction

  // bit 5 flags a character outside the alphabet
  function automatic logic [5:0] char_to_sym(input logic [7:0] c);
    logic [7:0] u;
    u = (codec_lower && c >= b32c_pkg::CHAR_LA && c <= b32c_pkg::CHAR_LZ) ?
        c - b32c_pkg::CASE_GAP : c;
    for (int i = 0; i < 32; i++) begin
      if (sym_to_char(5'(i)) == u) return 6'(i);
    end
    return 6'b100000;
  endfunction

  task automatic clear_group();
    grp_bits = '0;
    grp_cnt  = '0;
    data_cnt = '0;
  endtask

  task automatic reset_stream();
    clear_group();
    pad_seen   = 1'b0;
    discarding = 1'b0;
  endtask

  task automatic reject(input logic last, input logic [1:0] st);
    clear_group();
    pad_seen   = 1'b0;
    discarding = !last;
    add_result(b32_res_t'{8'h00, 1'b1, st});
  endtask

  task automatic predict_encode(input logic [7:0] b, input logic last);
    int n;
    int nch;
    logic [39:0] aligned;
    logic [7:0] ch;
    grp_bits = {grp_bits[31:0], b};
    grp_cnt  = grp_cnt + 4'd1;
    n = (grp_cnt > 4'd5) ? 5 : int'(grp_cnt);
    if (n < 5 && !last) return;
    case (n)
      1: nch = 2;
      2: nch = 4;
      3: nch = 5;
      4: nch = 7;
      default: nch = 8;
    endcase
    aligned = grp_bits << (8 * (5 - n));
    for (int i = 0; i < 8; i++) begin
      ch = (i < nch) ? sym_to_char(aligned[39 - 5*i -: 5]) : b32c_pkg::CHAR_PAD;
      add_result(b32_res_t'{ch, last && (i == 7), b32c_pkg::STATUS_OK});
    end
    clear_group();
  endtask

  task automatic predict_decode(input logic [7:0] c, input logic last);
    logic [5:0] v;
    int nb;
    logic [39:0] aligned;
    if (discarding) begin
      if (last) discarding = 1'b0;
      return;
    end
    if (c == b32c_pkg::CHAR_PAD) begin
      pad_seen = 1'b1;
      grp_cnt  = grp_cnt + 4'd1;
    end else begin
      v = char_to_sym(c);
      if (v[5] || pad_seen) begin
        reject(last, b32c_pkg::STATUS_BAD_CHAR);
        return;
      end
      grp_bits = {grp_bits[34:0], v[4:0]};
      data_cnt = data_cnt + 4'd1;
      grp_cnt  = grp_cnt + 4'd1;
    end
    if (grp_cnt >= 4'd8 || last) begin
      case (data_cnt)
        4'd2: nb = 1;
        4'd4: nb = 2;
        4'd5: nb = 3;
        4'd7: nb = 4;
        4'd8: nb = 5;
        default: nb = 0;
      endcase
      if (nb == 0) begin
        reject(last, b32c_pkg::STATUS_BAD_LEN);
        return;
      end
      aligned = grp_bits << (5 * (8 - data_cnt));
      for (int i = 0; i < nb; i++) begin
        add_result(b32_res_t'{aligned[39 - 8*i -: 8], last && (i == nb - 1),
                              b32c_pkg::STATUS_OK});
      end
      clear_group();
    end
    if (last) pad_seen = 1'b0;
  endtask

  // one process tracks config writes, predicts accepted inputs and checks results
  always @(posedge clk) begin
    int n_prior;
    b32_res_t want;
    if (!rst_n) begin
      codec_dir   = DIR_ENCODE;
      codec_lower = 1'b0;
      reset_stream();
    end else begin
      if (cfg_we) begin
        if (cfg_index == b32c_pkg::REG_DIRECTION) begin
          codec_dir = cfg_data[0];
          reset_stream();
        end else if (cfg_index == b32c_pkg::REG_ACCEPT_LOWER) begin
          codec_lower = cfg_data[0];
        end
      end
      if (in_valid && !in_stall) begin
        n_in++;
        n_prior = pending_results.size();
        if (codec_dir == DIR_DECODE) predict_decode(in_byte, in_last);
        else predict_encode(in_byte, in_last);
        if (item_typed) begin
          while (pending_results.size() > n_prior) void'(pending_results.pop_back());
          add_result(item_exp);
        end
      end
      if (out_valid && !out_stall) begin
        n_out++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, actual byte %02h last %0b status %0d",
                   $time, out_byte, out_last, out_status);
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (want.status != b32c_pkg::STATUS_OK) n_err++;
          if (out_byte !== want.data) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.data, out_byte);
            fail_cnt++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last mismatch, expected %0b, actual %0b",
                     $time, want.last, out_last);
            fail_cnt++;
          end
          if (out_status !== want.status) begin
            $display("%0t: out_status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last,
                           input logic typed, input b32_res_t exp);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_last    <= last;
    item_typed <= typed;
    item_exp   <= exp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_q.size(); i++) begin
      send_item(msg_q[i], i == msg_q.size() - 1, 1'b0, NO_EXP);
    end
  endtask

  // hold the sender off until every expected result is in, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic dir, input logic lower);
    cfg_we    <= 1'b1;
    cfg_index <= b32c_pkg::REG_DIRECTION;
    cfg_data  <= dir;
    @(posedge clk);
    cfg_index <= b32c_pkg::REG_ACCEPT_LOWER;
    cfg_data  <= lower;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] stim_char(input logic [4:0] v);
    logic [7:0] c;
    c = sym_to_char(v);
    if (v < 5'd26 && $urandom_range(99) < lower_pct) c = c + b32c_pkg::CASE_GAP;
    return c;
  endfunction

  // mostly well-formed groups; some bad characters, bad lengths and plain noise
  task automatic build_decode_msg();
    int kind;
    int groups;
    int d;
    msg_q.delete();
    kind = $urandom_range(9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 10)) add_char(8'($urandom_range(255)));
      return;
    end
    groups = $urandom_range(1, 3);
    for (int g = 0; g < groups; g++) begin
      if (g < groups - 1) begin
        d = 8;
      end else if (kind == 8) begin
        case ($urandom_range(3))
          0: d = 0;
          1: d = 1;
          2: d = 3;
          default: d = 6;
        endcase
      end else begin
        case ($urandom_range(4))
          0: d = 2;
          1: d = 4;
          2: d = 5;
          3: d = 7;
          default: d = 8;
        endcase
      end
      for (int k = 0; k < d; k++) add_char(stim_char(5'($urandom_range(31))));
      if (g == groups - 1 && (d == 0 || $urandom_range(1) == 1)) begin
        repeat (8 - d) add_char(b32c_pkg::CHAR_PAD);
      end
    end
    if (kind == 7) msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(255));
    if (kind == 6) add_char(stim_char(5'($urandom_range(31))));
  endtask

  initial begin
    logic cur_dir;
    logic cur_lower;
    int mode;
    int phase_idle;
    int phase_stall;
    int seg_items;
    logic quiet;

    cur_dir   = DIR_ENCODE;
    cur_lower = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].dir != cur_dir || DIRECTED[r].lower != cur_lower) begin
        drain();
        configure(DIRECTED[r].dir, DIRECTED[r].lower);
        cur_dir   = DIRECTED[r].dir;
        cur_lower = DIRECTED[r].lower;
      end
      send_item(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].exp);
    end

    // each idling mode sees both directions; lowercase acceptance is on only in the middle two modes
    for (int seg = 0; seg < 8; seg++) begin
      drain();
      mode = seg >> 1;
      case (mode)
        0: begin phase_idle = 0;  phase_stall = 0;  end
        1: begin phase_idle = 71; phase_stall = 0;  end
        2: begin phase_idle = 0;  phase_stall = 71; end
        default: begin phase_idle = 23; phase_stall = 23; end
      endcase
      cur_dir   = seg[0];
      cur_lower = seg[1] ^ seg[2];
      lower_pct = cur_lower ? 33 : 6;
      configure(cur_dir, cur_lower);
      seg_items = 0;
      while (seg_items < SEG_ITEMS) begin
        quiet = ($urandom_range(3) == 0);
        idle_pct = quiet ? 0 : phase_idle;
        stall_pct <= quiet ? 0 : phase_stall;
        if (cur_dir == DIR_DECODE) begin
          build_decode_msg();
        end else begin
          msg_q.delete();
          repeat ($urandom_range(1, 12)) add_char(8'($urandom_range(255)));
        end
        send_msg();
        seg_items += msg_q.size();
        if ($urandom_range(9) == 0) drain();
      end
    end

    drain();
    $display("covered %0d input transactions and %0d result transactions (%0d errors)",
             n_in, n_out, n_err);
    $display("both directions, lowercase on and off, four idling mixes");
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/b32c_pkg.sv
hw/rtl/b32c_front.sv
hw/rtl/b32c_fifo.sv
hw/rtl/b32c_back.sv
hw/rtl/base32_stream_codec.sv
hw/rtl/b32c_checker.sv
test/tb_base32_stream_codec.sv
